/* sv/bit_pattern_search_macros.svh */
// ----------------------------------------------------------------------------
// Bit pattern search assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef BIT_PATTERN_SEARCH_MACROS_SVH
`define BIT_PATTERN_SEARCH_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BPS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BPS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/bps_pkg.sv */
// ----------------------------------------------------------------------------
// Bit pattern search package
// Fixed constants and register indexes shared by the search modules.
// ----------------------------------------------------------------------------
package bps_pkg;

	localparam int BYTE_W     = 8;
	localparam int LANES      = 8;
	localparam int LEN_W      = 7;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = 3;

	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BITS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SEARCH_START = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SEARCH_END   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STREAM_BITS  = 3'd4;

endpackage

/* sv/bps_lane.sv */
// ----------------------------------------------------------------------------
// Bit pattern search lane
// Tests the one candidate match that ends K bits into the incoming byte.
// ----------------------------------------------------------------------------
module bps_lane #(
	parameter int K             = 1,
	parameter int PAT_W         = 64,
	parameter int POSITION_BITS = 20
) (
	input  logic [PAT_W-1:0]            history,
	input  logic [bps_pkg::BYTE_W-1:0]  stream_byte,
	input  logic [POSITION_BITS:0]      bits_seen,
	input  logic [bps_pkg::LEN_W-1:0]   pattern_len,
	input  logic [PAT_W-1:0]            pattern_mask,
	input  logic [PAT_W-1:0]            pattern_want,
	input  logic [POSITION_BITS-1:0]    search_start,
	input  logic [POSITION_BITS-1:0]    search_end,
	input  logic [POSITION_BITS-1:0]    stream_bits,
	output logic                        hit,
	output logic [POSITION_BITS:0]      position
);
	import bps_pkg::*;

	localparam int EW = POSITION_BITS + 2;

	logic [PAT_W+BYTE_W-1:0] joined;
	logic [PAT_W-1:0]        window;
	logic [EW-1:0]           end_pos;
	logic [EW-1:0]           len_ext;
	logic [EW-1:0]           begin_pos;
	logic                    in_range;

	assign joined    = {history, stream_byte};
	// Window of the last PAT_W bits ending K bits into the new byte.
	assign window    = joined[PAT_W-1+BYTE_W-K : BYTE_W-K];
	assign end_pos   = {1'b0, bits_seen} + EW'(K);
	assign len_ext   = EW'(pattern_len);
	assign begin_pos = end_pos - len_ext;

	assign in_range = (end_pos >= len_ext)
		&& (begin_pos >= {2'b00, search_start})
		&& (end_pos <= {2'b00, search_end})
		&& (end_pos <= {2'b00, stream_bits});

	assign hit      = in_range && ((window & pattern_mask) == pattern_want);
	assign position = begin_pos[POSITION_BITS:0];

endmodule

/* sv/bps_merge.sv */
// ----------------------------------------------------------------------------
// Bit pattern search merge
// Picks the earliest lane hit and tracks whether the stream has reported.
// ----------------------------------------------------------------------------
module bps_merge #(
	parameter int POSITION_BITS = 20
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic                        last,
	input  logic [bps_pkg::LANES-1:0]   lane_hit,
	input  logic [POSITION_BITS:0]      lane_pos [bps_pkg::LANES],
	input  logic [POSITION_BITS-1:0]    search_end,
	output logic                        emit,
	output logic                        found,
	output logic [POSITION_BITS:0]      position
);
	import bps_pkg::*;

	logic                   reported_q;
	logic                   any_hit;
	logic [POSITION_BITS:0] hit_pos;

	// The lowest lane ends earliest in the byte, so it wins.
	always_comb begin
		hit_pos = '0;
		for (int i = LANES - 1; i >= 0; i--) begin
			if (lane_hit[i]) begin
				hit_pos = lane_pos[i];
			end
		end
	end

	assign any_hit  = !reported_q && (|lane_hit);
	assign emit     = any_hit || (last && !reported_q);
	assign found    = any_hit;
	assign position = any_hit ? hit_pos
		: ({1'b0, search_end} + (POSITION_BITS+1)'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reported_q <= 1'b0;
		end else if (step) begin
			if (last) begin
				reported_q <= 1'b0;
			end else if (any_hit) begin
				reported_q <= 1'b1;
			end
		end
	end

endmodule

/* sv/bit_pattern_search.sv */
// ----------------------------------------------------------------------------
// Bit pattern search
// Finds the first bit position at which a configured pattern occurs.
// ----------------------------------------------------------------------------
// Path: a byte's lane results are held in the lane register, merged, then held in the output register.
// Throughput: one byte per cycle while the result stream is not stalled; the eight lane tests of a byte run together.
// Reset (arst_n low): configuration and valid registers take their reset values, stream state clears.
// A stalled output holds its result while one further byte may still enter.
// ----------------------------------------------------------------------------
module bit_pattern_search #(
	parameter int MAX_PATTERN_BITS = 64,
	parameter int POSITION_BITS    = 20
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	// Configuration write port
	input  logic                                       cfg_we,
	input  logic [bps_pkg::CFG_IDX_W-1:0]              cfg_index,
	input  logic [bps_pkg::CFG_DATA_W-1:0]             cfg_data,
	// Input stream
	input  logic                                       s_axis_tvalid,
	output logic                                       s_axis_tready,
	input  logic [bps_pkg::BYTE_W-1:0]                 s_axis_tdata, // [7:0] stream_byte
	input  logic                                       s_axis_tlast, // last_byte
	// Result stream
	output logic                                       m_axis_tvalid,
	input  logic                                       m_axis_tready,
	output logic [((POSITION_BITS+1+7)/8)*8-1:0]       m_axis_tdata, // match_position, zero pad
	output logic                                       m_axis_tuser  // found
);
	import bps_pkg::*;

	localparam int PAT_W   = MAX_PATTERN_BITS;
	localparam int NW      = POSITION_BITS + 1;
	localparam int OUT_W   = ((POSITION_BITS + 1 + 7) / 8) * 8;

	// Configuration registers.
	logic [PAT_W-1:0]         pattern_q;
	logic [LEN_W-1:0]         pattern_bits_q;
	logic [POSITION_BITS-1:0] search_start_q;
	logic [POSITION_BITS-1:0] search_end_q;
	logic [POSITION_BITS-1:0] stream_bits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q      <= '0;
			pattern_bits_q <= LEN_W'(8);
			search_start_q <= '0;
			search_end_q   <= '0;
			stream_bits_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PATTERN_WORD: pattern_q      <= cfg_data[PAT_W-1:0];
				REG_PATTERN_BITS: pattern_bits_q <= cfg_data[LEN_W-1:0];
				REG_SEARCH_START: search_start_q <= cfg_data[POSITION_BITS-1:0];
				REG_SEARCH_END:   search_end_q   <= cfg_data[POSITION_BITS-1:0];
				REG_STREAM_BITS:  stream_bits_q  <= cfg_data[POSITION_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Effective pattern length: zero is taken as one, and anything beyond the
	// history width is clipped to it. The mask and the masked pattern follow
	// from the length; the user must change them only while the block is idle, not enforced here.
	logic [LEN_W-1:0] pattern_len;
	logic [PAT_W-1:0] pattern_mask;
	logic [PAT_W-1:0] pattern_want;

	always_comb begin
		if (pattern_bits_q == '0) begin
			pattern_len = LEN_W'(1);
		end else if (pattern_bits_q > LEN_W'(PAT_W)) begin
			pattern_len = LEN_W'(PAT_W);
		end else begin
			pattern_len = pattern_bits_q;
		end
		for (int i = 0; i < PAT_W; i++) begin
			pattern_mask[i] = (LEN_W'(i) < pattern_len);
		end
	end

	assign pattern_want = pattern_q & pattern_mask;

	// Handshake and pipeline flow. The output register frees up when it is
	// empty or its transaction completes; the lane register frees up when it
	// is empty or can hand its byte to the merge stage.
	logic out_valid_q;
	logic valid_s1;
	logic out_free;
	logic s1_free;
	logic in_accept;
	logic merge_step;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign s1_free       = !valid_s1 || out_free;
	assign s_axis_tready = s1_free;
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign merge_step    = valid_s1 && out_free;

	// Stream state: the most recent bits and a saturating count of bits seen.
	// Both move with every accepted byte, whatever the lanes find, and clear
	// after the last byte of a stream.
	logic [PAT_W-1:0]        history_q;
	logic [PAT_W+BYTE_W-1:0] history_next;
	logic [NW-1:0]           bits_seen_q;
	logic [NW:0]             seen_plus;

	assign history_next = {history_q, s_axis_tdata};
	assign seen_plus    = {1'b0, bits_seen_q} + (NW+1)'(BYTE_W);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			history_q   <= '0;
			bits_seen_q <= '0;
		end else if (in_accept) begin
			if (s_axis_tlast) begin
				history_q   <= '0;
				bits_seen_q <= '0;
			end else begin
				history_q   <= history_next[PAT_W-1:0];
				bits_seen_q <= seen_plus[NW] ? '1 : seen_plus[NW-1:0];
			end
		end
	end

	// One lane per bit of the byte: lane i tests the candidate that ends i+1
	// bits into the incoming byte.
	logic [LANES-1:0] lane_hit;
	logic [NW-1:0]    lane_pos [LANES];

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		bps_lane #(
			.K             (g + 1),
			.PAT_W         (PAT_W),
			.POSITION_BITS (POSITION_BITS)
		) u_lane (
			.history      (history_q),
			.stream_byte  (s_axis_tdata),
			.bits_seen    (bits_seen_q),
			.pattern_len  (pattern_len),
			.pattern_mask (pattern_mask),
			.pattern_want (pattern_want),
			.search_start (search_start_q),
			.search_end   (search_end_q),
			.stream_bits  (stream_bits_q),
			.hit          (lane_hit[g]),
			.position     (lane_pos[g])
		);
	end

	// Lane results register; the lanes see no reported flag, so they need
	// nothing from later bytes.
	logic [LANES-1:0] lane_hit_s1;
	logic [NW-1:0]    lane_pos_s1 [LANES];
	logic             last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= in_accept;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			lane_hit_s1 <= lane_hit;
			lane_pos_s1 <= lane_pos;
			last_s1     <= s_axis_tlast;
		end
	end

	// Merge stage: earliest hit, suppressed once the stream has reported;
	// a failure goes out with the last byte if nothing was reported.
	logic          merge_emit;
	logic          merge_found;
	logic [NW-1:0] merge_pos;

	bps_merge #(
		.POSITION_BITS (POSITION_BITS)
	) u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (merge_step),
		.last       (last_s1),
		.lane_hit   (lane_hit_s1),
		.lane_pos   (lane_pos_s1),
		.search_end (search_end_q),
		.emit       (merge_emit),
		.found      (merge_found),
		.position   (merge_pos)
	);

	// Output register.
	logic          found_q;
	logic [NW-1:0] position_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= merge_step && merge_emit;
		end
	end

	always_ff @(posedge clk) begin
		if (merge_step && merge_emit && out_free) begin
			found_q    <= merge_found;
			position_q <= merge_pos;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = found_q;
	assign m_axis_tdata  = OUT_W'(position_q);

	// Assertions.
`include "bit_pattern_search_macros.svh"

	`BPS_ASSERT_SAME(a_seen_step, 1'b1, (bits_seen_q[2:0] == 3'd0) || (bits_seen_q == '1), "bits seen count off byte grid")
	`BPS_ASSERT_NEXT(a_last_clears, in_accept && s_axis_tlast, bits_seen_q == '0, "last byte did not clear the bit count")
	`BPS_ASSERT_NEXT(a_hit_marks, merge_step && merge_emit && merge_found && !last_s1, u_merge.reported_q, "match not recorded")
	`BPS_ASSERT_NEXT(a_single_result, merge_step && u_merge.reported_q && !last_s1, !out_valid_q, "second result in one stream")

endmodule

/* tb/tb_bit_pattern_search.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit pattern search regression
// Streams bytes into the search block and checks each reported match or
// failure against a cycle-free predictor kept alongside the stimulus.
// ----------------------------------------------------------------------------
module tb_bit_pattern_search;
	import bps_pkg::*;

	localparam int POS_W        = 20;
	localparam int RES_W        = ((POS_W + 1 + 7) / 8) * 8;
	localparam int PATTERN_MAX  = 64;
	localparam int SEEN_MAX     = (1 << (POS_W + 1)) - 1;
	localparam int SETTLE_WAIT  = 6;
	localparam int RANDOM_ITEMS = 1450;
	localparam int LONG_BYTES   = 160;
	localparam int CYCLE_LIMIT  = 2000000;
	localparam int REPORT_CAP   = 40;

	typedef struct packed {
		logic              found;
		logic [POS_W:0]    position;
	} search_result_t;

	typedef enum int {RX_OPEN, RX_COIN, RX_BURSTY, RX_SPARSE} rx_mode_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [BYTE_W-1:0]      s_axis_tdata; // [7:0] stream_byte
	logic                   s_axis_tlast; // last_byte
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [RES_W-1:0]       m_axis_tdata; // [20:0] match_position, [23:21] zero
	logic                   m_axis_tuser; // found

	// Register copies kept by the predictor, masked to the register widths.
	logic [63:0]            pat_reg;
	logic [6:0]             len_reg;
	logic [POS_W-1:0]       from_reg;
	logic [POS_W-1:0]       upto_reg;
	logic [POS_W-1:0]       limit_reg;

	// Stream state of the predictor.
	logic [63:0]            hist_bits;
	int                     seen_count;
	bit                     answered;

	search_result_t         pending_results[$];
	logic [7:0]             stream_buf [0:63];

	int                     errors = 0;
	int                     cycles = 0;
	int                     random_items = 0;
	int                     burst_left = 0;
	bit                     sender_steady = 1'b0;
	rx_mode_t               rx_mode = RX_OPEN;
	int                     rx_left = 0;
	int                     rx_stall = 0;

	bit_pattern_search #(
		.MAX_PATTERN_BITS(PATTERN_MAX),
		.POSITION_BITS(POS_W)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always #4 clk = ~clk;

	// Works out what one accepted byte should report. The eight candidate
	// windows end inside the new byte; the earliest one that qualifies and
	// matches wins. A failure is only reported on the last byte, and only
	// if the stream has not already produced a match.
	function automatic void predict_byte(input logic [7:0] b, input logic l);
		int             len;
		int             e;
		int             k;
		logic [63:0]    mask;
		logic [63:0]    want;
		logic [63:0]    window;
		search_result_t res;
		bit             hit;
		len = int'(len_reg);
		if (len < 1)
			len = 1;
		if (len > PATTERN_MAX)
			len = PATTERN_MAX;
		mask = (len >= 64) ? '1 : ((64'd1 << len) - 64'd1);
		want = pat_reg & mask;
		hit = 1'b0;
		res = '0;
		if (!answered) begin
			for (k = 1; k <= 8; k++) begin
				e = seen_count + k;
				// A window that would begin before bit 0, begin before the
				// start, or reach past the end or the stream length is skipped.
				if (!hit && e >= len && e - len >= int'(from_reg) &&
						e <= int'(upto_reg) && e <= int'(limit_reg)) begin
					window = (hist_bits << k) | ({56'd0, b} >> (8 - k));
					if ((window & mask) == want) begin
						hit = 1'b1;
						res.found = 1'b1;
						res.position = (POS_W + 1)'(e - len);
					end
				end
			end
		end
		hist_bits = {hist_bits[55:0], b};
		// The bit count saturates on very long streams.
		seen_count = (seen_count + 8 > SEEN_MAX) ? SEEN_MAX : seen_count + 8;
		if (hit) begin
			answered = 1'b1;
			pending_results.push_back(res);
		end else if (l && !answered) begin
			res.found = 1'b0;
			res.position = {1'b0, upto_reg} + 1'b1;
			pending_results.push_back(res);
		end
		if (l) begin
			hist_bits = '0;
			seen_count = 0;
			answered = 1'b0;
		end
	endfunction

	// Every result transaction is compared with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= REPORT_CAP)
					$display("%0t: unexpected result, expected none, actual found=%0b position=%0d",
						$time, m_axis_tuser, m_axis_tdata);
			end else begin
				if (m_axis_tuser !== pending_results[0].found) begin
					errors++;
					if (errors <= REPORT_CAP)
						$display("%0t: found mismatch, expected %0b, actual %0b",
							$time, pending_results[0].found, m_axis_tuser);
				end
				if (m_axis_tdata !== RES_W'(pending_results[0].position)) begin
					errors++;
					if (errors <= REPORT_CAP)
						$display("%0t: position mismatch, expected %0d, actual %0d",
							$time, pending_results[0].position, m_axis_tdata);
				end
				void'(pending_results.pop_front());
			end
		end
	end

	// The receiver changes its habit at random intervals: always ready,
	// a coin toss, mostly ready with long stalls, or rarely ready.
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(32, 400);
		end
		rx_left--;
		case (rx_mode)
		RX_OPEN: m_axis_tready <= 1'b1;
		RX_COIN: m_axis_tready <= 1'($urandom_range(0, 1));
		RX_BURSTY: begin
			if (rx_stall != 0) begin
				rx_stall--;
				m_axis_tready <= 1'b0;
			end else if ($urandom_range(0, 15) == 0) begin
				rx_stall = $urandom_range(1, 20);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
		default: m_axis_tready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// Guards against a hang anywhere in the run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("bit_pattern_search regression: fail");
			$finish;
		end
	end

	// Sends one byte. The sender works in bursts; at the start of each burst
	// it may drop tvalid for a random gap, unless it is in a steady stretch.
	task automatic send_byte(input logic [7:0] b, input logic l);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = sender_steady ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= l;
		do
			@(posedge clk);
		while (s_axis_tready !== 1'b1);
		predict_byte(b, l);
	endtask

	// Holds the sender off until every expected result has come out, then
	// lets the pipeline run dry.
	task automatic settle_results();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_WAIT) @(posedge clk);
	endtask

	// One register write; the caller lowers the write enable afterwards.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		case (idx)
		REG_PATTERN_WORD: pat_reg = value;
		REG_PATTERN_BITS: len_reg = value[6:0];
		REG_SEARCH_START: from_reg = value[POS_W-1:0];
		REG_SEARCH_END: upto_reg = value[POS_W-1:0];
		REG_STREAM_BITS: limit_reg = value[POS_W-1:0];
		default: ;
		endcase
	endtask

	// Writes the whole search set-up; only called while the block is idle.
	task automatic load_search(input logic [63:0] pat_word, input logic [63:0] len_word,
			input logic [63:0] from_word, input logic [63:0] upto_word,
			input logic [63:0] bits_word);
		write_reg(REG_PATTERN_WORD, pat_word);
		write_reg(REG_PATTERN_BITS, len_word);
		write_reg(REG_SEARCH_START, from_word);
		write_reg(REG_SEARCH_END, upto_word);
		write_reg(REG_STREAM_BITS, bits_word);
		cfg_we <= 1'b0;
	endtask

	// Sends the first count bytes of the buffer as one stream, optionally
	// holding off before one of them until all results are in.
	task automatic send_buffer(input int count, input int pause_at);
		int i;
		for (i = 0; i < count; i++) begin
			if (i == pause_at)
				settle_results();
			send_byte(stream_buf[i], i == count - 1);
		end
	endtask

	// Straight after reset the end position is 0, so nothing can qualify and
	// the stream must fail with position 1.
	task automatic test_reset_values();
		stream_buf[0] = 8'h00;
		stream_buf[1] = 8'hA5;
		send_buffer(2, -1);
	endtask

	// Length limits: an oversized length acts as 64 (here matching on the last
	// byte), and a zero length acts as 1. High bits above the length and start
	// registers' widths are set so that they must be ignored.
	task automatic test_length_limits();
		int i;
		settle_results();
		load_search('1, 64'hFFFF_FF00_0000_00FF, 64'hABCD_0000_0000_0000, 100, 64);
		for (i = 0; i < 8; i++)
			stream_buf[i] = 8'hFF;
		send_buffer(8, -1);
		settle_results();
		load_search(64'h8000_0000_0000_0001, 64'h80, 0, 8, 8);
		stream_buf[0] = 8'h0F;
		send_buffer(1, -1);
	endtask

	// Window rules: start not below end, a match running into padding, a
	// candidate that would begin before the stream, and the lowest position
	// winning inside one byte followed by silence for the rest of the stream.
	task automatic test_window_cases();
		settle_results();
		load_search(64'hFF, 8, 9, 9, 16);
		stream_buf[0] = 8'hFF;
		stream_buf[1] = 8'hFF;
		send_buffer(2, -1);
		settle_results();
		load_search(64'hFF, 8, 0, 16, 11);
		stream_buf[0] = 8'h0F;
		stream_buf[1] = 8'hFF;
		send_buffer(2, -1);
		settle_results();
		load_search(64'h00, 8, 0, 16, 16);
		send_buffer(2, -1);
		settle_results();
		load_search(64'h3, 2, 3, 40, 40);
		stream_buf[0] = 8'hFF;
		stream_buf[1] = 8'hFF;
		stream_buf[2] = 8'h00;
		// The sender waits here for the match of the first byte to drain.
		send_buffer(3, 1);
	endtask

	// One random stream. Most streams carry the pattern at a random bit
	// offset with a search window that often contains it; the rest are noise.
	// About a quarter keep the previous set-up and follow back to back.
	task automatic random_stream();
		int          nbytes;
		int          total;
		int          len_eff;
		int          plant;
		int          pos;
		int          i;
		int          pick;
		int          pause_at;
		logic [63:0] pat_v;
		logic [63:0] hi;
		logic [6:0]  len_v;
		int          from_v;
		int          upto_v;
		int          bits_v;
		bit          reconfigure;
		nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
		total = nbytes * 8;
		reconfigure = ($urandom_range(0, 3) != 0);
		if (reconfigure) begin
			pick = $urandom_range(0, 19);
			case (pick)
			0: len_v = 7'd0;
			1: len_v = 7'($urandom_range(65, 127));
			2: len_v = 7'd64;
			default: len_v = 7'($urandom_range(1, (total < 64) ? total : 64));
			endcase
			pat_v = {$urandom, $urandom};
		end else begin
			len_v = len_reg;
			pat_v = pat_reg;
		end
		len_eff = (len_v == 0) ? 1 : ((len_v > PATTERN_MAX) ? PATTERN_MAX : int'(len_v));
		for (i = 0; i < nbytes; i++) begin
			pick = $urandom_range(0, 7);
			stream_buf[i] = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
		end
		if ($urandom_range(0, 4) != 0 && len_eff <= total) begin
			plant = $urandom_range(0, total - len_eff);
			for (i = 0; i < len_eff; i++) begin
				pos = plant + i;
				stream_buf[pos / 8][7 - pos % 8] = pat_v[len_eff - 1 - i];
			end
		end else begin
			plant = $urandom_range(0, total);
		end
		if (reconfigure) begin
			from_v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, total + 8) :
				$urandom_range(0, plant);
			upto_v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, total + 8) :
				$urandom_range(plant + len_eff, total + 8);
			bits_v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, total) : total;
			hi = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : 64'd0;
			settle_results();
			load_search(pat_v, (hi << 7) | len_v, (hi << POS_W) | from_v,
				(hi << POS_W) | upto_v, (hi << POS_W) | bits_v);
		end
		sender_steady = ($urandom_range(0, 2) == 0);
		pause_at = ($urandom_range(0, 11) == 0) ? $urandom_range(1, nbytes) : -1;
		send_buffer(nbytes, pause_at);
		random_items += nbytes;
	endtask

	task automatic test_random_streams();
		while (random_items < RANDOM_ITEMS)
			random_stream();
	endtask

	// Two streams well beyond the history length. The first holds a
	// 24-bit pattern near its end inside a window that opens late; the
	// second is all zeros and must fail with the end position plus one.
	task automatic test_long_streams();
		int          i;
		int          n;
		int          plant_byte;
		logic [7:0]  b;
		settle_results();
		sender_steady = 1'b1;
		n = LONG_BYTES;
		plant_byte = n - 12;
		load_search(64'h5A3C96, 24, 64'(plant_byte * 8 - 100), 64'(n * 8), 64'(n * 8));
		for (i = 0; i < n; i++) begin
			if (i == plant_byte)
				b = 8'h5A;
			else if (i == plant_byte + 1)
				b = 8'h3C;
			else if (i == plant_byte + 2)
				b = 8'h96;
			else
				b = 8'h00;
			send_byte(b, i == n - 1);
		end
		n = LONG_BYTES / 2;
		for (i = 0; i < n; i++)
			send_byte(8'h00, i == n - 1);
		sender_steady = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_PATTERN_WORD;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		m_axis_tready = 1'b0;
		pat_reg = '0;
		len_reg = 7'd8;
		from_reg = '0;
		upto_reg = '0;
		limit_reg = '0;
		hist_bits = '0;
		seen_count = 0;
		answered = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_length_limits();
		test_window_cases();
		test_random_streams();
		test_long_streams();

		settle_results();
		if (errors == 0) begin
			$display("bit_pattern_search regression: pass");
		end else begin
			$display("bit_pattern_search regression: fail");
		end
		$finish;
	end

endmodule

/* filelist.f */
+incdir+sv
sv/bps_pkg.sv
sv/bps_lane.sv
sv/bps_merge.sv
sv/bit_pattern_search.sv
tb/tb_bit_pattern_search.sv
